@@ rtl/numeric_format_converter_core_assert.svh @@
// assertion macros used by the checker file
`ifndef NUMERIC_FORMAT_CONVERTER_CORE_ASSERT_SVH
`define NUMERIC_FORMAT_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, idle during reset
`define NFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nfc assertion failed");

// next-cycle implication, idle during reset
`define NFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nfc assertion failed");

`endif

@@ rtl/nfc_pkg.sv @@
// shared codes, types and format helpers of the format converter
package nfc_pkg;

    localparam logic [2:0] FMT_I8   = 3'd0;
    localparam logic [2:0] FMT_I16  = 3'd1;
    localparam logic [2:0] FMT_I32  = 3'd2;
    localparam logic [2:0] FMT_BF16 = 3'd3;
    localparam logic [2:0] FMT_F16  = 3'd4;
    localparam logic [2:0] FMT_TF32 = 3'd5;
    localparam logic [2:0] FMT_F32  = 3'd6;

    localparam logic [2:0] RM_RNE = 3'd0;
    localparam logic [2:0] RM_RTZ = 3'd1;
    localparam logic [2:0] RM_RUP = 3'd2;
    localparam logic [2:0] RM_RDN = 3'd3;
    localparam logic [2:0] RM_RNA = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_UNSUP   = 2'd2;

    localparam logic [1:0] REG_SRC_FMT = 2'd0;
    localparam logic [1:0] REG_DST_FMT = 2'd1;
    localparam logic [1:0] REG_RND     = 2'd2;

    localparam int PADDR_W = 4;
    localparam int MAX_INFLIGHT = 4;

    // per-word flags carried down the pipe
    typedef struct packed {
        logic        sign;
        logic        nan;
        logic        inf;
        logic        zero;
        logic        unsup;
        logic [22:0] smant;
        logic [4:0]  smw;
    } t_flags;

    function automatic logic [4:0] fmt_mw(input logic [2:0] f);
        logic [4:0] mw;
        case (f)
            FMT_BF16: mw = 5'd7;
            FMT_F16:  mw = 5'd10;
            FMT_TF32: mw = 5'd10;
            default:  mw = 5'd23;
        endcase
        return mw;
    endfunction

    function automatic logic [7:0] fmt_bias(input logic [2:0] f);
        return (f == FMT_F16) ? 8'd15 : 8'd127;
    endfunction

    function automatic logic [7:0] fmt_emax(input logic [2:0] f);
        return (f == FMT_F16) ? 8'd31 : 8'd255;
    endfunction

    function automatic logic [31:0] fp_pack(input logic [2:0] f, input logic s,
                                            input logic [7:0] e, input logic [22:0] m);
        logic [31:0] w;
        case (f)
            FMT_BF16: w = {16'd0, s, e, m[6:0]};
            FMT_F16:  w = {16'd0, s, e[4:0], m[9:0]};
            FMT_TF32: w = {s, e, m[9:0], 13'd0};
            default:  w = {s, e, m};
        endcase
        return w;
    endfunction

    function automatic logic round_inc(input logic [2:0] mode, input logic neg,
                                       input logic g, input logic st, input logic lsb);
        logic inc;
        case (mode)
            RM_RTZ:  inc = 1'b0;
            RM_RUP:  inc = (g | st) & ~neg;
            RM_RDN:  inc = (g | st) & neg;
            RM_RNA:  inc = g;
            default: inc = g & (st | lsb);
        endcase
        return inc;
    endfunction

endpackage

@@ rtl/numeric_format_converter_core.sv @@
// numeric format converter: int8/16/32 and bf16/f16/tf32/f32 conversion pipeline
// One word enters per cycle when the pipe is not stalled and passes through the registered
// stages decode, normalize, round and pack; each stage holds its word only while the
// stage after it is full and stalled, so back-pressure on the output fills the
// pipe up to four words before the input stops. Formats and rounding mode come
// from three APB registers at byte addresses 0, 4 and 8 (source format, destination format,
// rounding mode). The user must change them only while the pipe is empty; it is not enforced.
// o_status reports 1 for NaN, infinity or out-of-range float to int, and 2 for an
// int to int pair or an unused format code; the result word is zero in both cases.
module numeric_format_converter_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nfc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [31:0]                 i_source_word,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [31:0]                 o_result_word,
    output logic [1:0]                  o_status
);
    import nfc_pkg::*;

    logic [2:0] r_src_fmt, r_dst_fmt, r_mode;

    // config port
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= FMT_F32;
            r_dst_fmt <= FMT_F32;
            r_mode    <= RM_RNE;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_SRC_FMT: r_src_fmt <= pwdata[2:0];
                REG_DST_FMT: r_dst_fmt <= pwdata[2:0];
                REG_RND:     r_mode    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SRC_FMT: prdata = {29'd0, r_src_fmt};
            REG_DST_FMT: prdata = {29'd0, r_dst_fmt};
            REG_RND:     prdata = {29'd0, r_mode};
            default:     prdata = 32'd0;
        endcase
    end

    // stage valid bits and ready chain
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: decode
    t_flags             n_f1;
    logic [31:0]        n_mag1;
    logic signed [9:0]  n_ex1;
    logic [31:0]        d_iv;
    logic [7:0]         d_ef, d_emax, d_bias;
    logic [4:0]         d_mw;

    always_comb begin
        n_f1       = '0;
        n_mag1     = '0;
        n_ex1      = '0;
        d_iv       = '0;
        d_ef       = '0;
        d_mw       = fmt_mw(r_src_fmt);
        d_bias     = fmt_bias(r_src_fmt);
        d_emax     = fmt_emax(r_src_fmt);
        n_f1.unsup = (r_src_fmt > FMT_F32) || (r_dst_fmt > FMT_F32)
                     || (r_src_fmt <= FMT_I32 && r_dst_fmt <= FMT_I32);
        if (r_src_fmt <= FMT_I32) begin
            case (r_src_fmt)
                FMT_I8:  d_iv = {{24{i_source_word[7]}}, i_source_word[7:0]};
                FMT_I16: d_iv = {{16{i_source_word[15]}}, i_source_word[15:0]};
                default: d_iv = i_source_word;
            endcase
            n_f1.sign = d_iv[31];
            n_mag1    = d_iv[31] ? (~d_iv + 32'd1) : d_iv;
            n_f1.zero = (d_iv == 32'd0);
        end else begin
            case (r_src_fmt)
                FMT_BF16: begin
                    n_f1.sign  = i_source_word[15];
                    d_ef       = i_source_word[14:7];
                    n_f1.smant = {16'd0, i_source_word[6:0]};
                end
                FMT_F16: begin
                    n_f1.sign  = i_source_word[15];
                    d_ef       = {3'd0, i_source_word[14:10]};
                    n_f1.smant = {13'd0, i_source_word[9:0]};
                end
                FMT_TF32: begin
                    n_f1.sign  = i_source_word[31];
                    d_ef       = i_source_word[30:23];
                    n_f1.smant = {13'd0, i_source_word[22:13]};
                end
                default: begin
                    n_f1.sign  = i_source_word[31];
                    d_ef       = i_source_word[30:23];
                    n_f1.smant = i_source_word[22:0];
                end
            endcase
            n_f1.smw = d_mw;
            if (d_ef == d_emax) begin
                n_f1.inf = (n_f1.smant == 23'd0);
                n_f1.nan = (n_f1.smant != 23'd0);
            end else if (d_ef == 8'd0) begin
                n_f1.zero = (n_f1.smant == 23'd0);
                n_mag1    = {9'd0, n_f1.smant};
                n_ex1     = 10'sd1 - $signed({2'b00, d_bias}) - $signed({5'd0, d_mw});
            end else begin
                n_mag1 = {9'd0, n_f1.smant} | (32'd1 << d_mw);
                n_ex1  = $signed({2'b00, d_ef}) - $signed({2'b00, d_bias})
                         - $signed({5'd0, d_mw});
            end
        end
    end

    t_flags            r_f1;
    logic [31:0]       r_mag1;
    logic signed [9:0] r_ex1;
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_f1   <= n_f1;
            r_mag1 <= n_mag1;
            r_ex1  <= n_ex1;
        end
    end

    // stage 2: leading one and shift amount
    logic [4:0]         s2_tb;
    logic signed [9:0]  s2_e, s2_emin, s2_qb, n_q2;
    logic signed [10:0] s2_sh;
    logic               n_left2, n_big2;
    logic [4:0]         n_shl2;
    logic [5:0]         n_shr2;

    always_comb begin
        s2_tb = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_mag1[i]) s2_tb = 5'(i);
        end
        s2_e    = $signed({5'd0, s2_tb}) + r_ex1;
        s2_emin = 10'sd1 - $signed({2'b00, fmt_bias(r_dst_fmt)});
        s2_qb   = (s2_e < s2_emin) ? s2_emin : s2_e;
        n_q2    = s2_qb - $signed({5'd0, fmt_mw(r_dst_fmt)});
        n_big2  = 1'b0;
        if (r_dst_fmt <= FMT_I32) begin
            s2_sh  = -$signed({r_ex1[9], r_ex1});
            n_big2 = (s2_e >= 10'sd32);
        end else begin
            s2_sh = $signed({n_q2[9], n_q2}) - $signed({r_ex1[9], r_ex1});
        end
        n_left2 = (s2_sh <= 11'sd0);
        n_shl2  = 5'(-s2_sh);
        n_shr2  = (s2_sh > 11'sd40) ? 6'd40 : 6'(s2_sh);
    end

    t_flags            r_f2;
    logic [31:0]       r_mag2;
    logic signed [9:0] r_q2;
    logic              r_left2, r_big2;
    logic [4:0]        r_shl2;
    logic [5:0]        r_shr2;
    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_f2    <= r_f1;
            r_mag2  <= r_mag1;
            r_q2    <= n_q2;
            r_left2 <= n_left2;
            r_big2  <= n_big2;
            r_shl2  <= n_shl2;
            r_shr2  <= n_shr2;
        end
    end

    // stage 3: align and round
    logic [63:0] s3_wide;
    logic [33:0] s3_base, n_n3;
    logic        s3_g, s3_st, s3_inc;
    logic [5:0]  s3_gi;

    always_comb begin
        s3_wide = {32'd0, r_mag2};
        s3_gi   = r_shr2 - 6'd1;
        s3_g    = s3_wide[s3_gi];
        s3_st   = |(s3_wide & ((64'd1 << s3_gi) - 64'd1));
        s3_base = r_left2 ? (34'(r_mag2) << r_shl2) : 34'(s3_wide >> r_shr2);
        s3_inc  = !r_left2 && round_inc(r_mode, r_f2.sign, s3_g, s3_st, s3_base[0]);
        n_n3    = s3_base + 34'(s3_inc);
    end

    t_flags            r_f3;
    logic [33:0]       r_n3;
    logic signed [9:0] r_q3;
    logic              r_big3;
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_f3   <= r_f2;
            r_n3   <= n_n3;
            r_q3   <= r_q2;
            r_big3 <= r_big2;
        end
    end

    // stage 4: pack and range check
    logic [4:0]         s4_mw;
    logic [7:0]         s4_emax, s4_bias;
    logic               s4_ovf, s4_norm, s4_inf_ok, s4_bad;
    logic [33:0]        s4_n, s4_lim, s4_v;
    logic signed [9:0]  s4_q;
    logic signed [10:0] s4_eb;
    logic [22:0]        s4_mmask, s4_pm;
    logic [5:0]         s4_w;
    logic [31:0]        n_res;
    logic [1:0]         n_st;

    always_comb begin
        s4_mw     = fmt_mw(r_dst_fmt);
        s4_emax   = fmt_emax(r_dst_fmt);
        s4_bias   = fmt_bias(r_dst_fmt);
        s4_mmask  = (23'd1 << s4_mw) - 23'd1;
        s4_ovf    = (r_n3 >> (s4_mw + 5'd1)) != 34'd0;
        s4_n      = s4_ovf ? (r_n3 >> 1) : r_n3;
        s4_q      = r_q3 + $signed({9'd0, s4_ovf});
        s4_norm   = (s4_n >> s4_mw) != 34'd0;
        s4_eb     = $signed({s4_q[9], s4_q}) + $signed({6'd0, s4_mw})
                    + $signed({3'd0, s4_bias});
        s4_inf_ok = !((r_mode == RM_RTZ) || (r_mode == RM_RUP && r_f3.sign)
                      || (r_mode == RM_RDN && !r_f3.sign));
        s4_pm     = (s4_mw >= r_f3.smw) ? (r_f3.smant << (s4_mw - r_f3.smw))
                                        : (r_f3.smant >> (r_f3.smw - s4_mw));
        s4_pm     = s4_pm | (23'd1 << (s4_mw - 5'd1));
        s4_w      = (r_dst_fmt == FMT_I8) ? 6'd8 : (r_dst_fmt == FMT_I16) ? 6'd16 : 6'd32;
        s4_lim    = 34'd1 << (s4_w - 6'd1);
        s4_v      = r_f3.sign ? (~r_n3 + 34'd1) : r_n3;
        s4_bad    = 1'b0;
        n_res     = '0;
        n_st      = ST_OK;
        if (r_f3.unsup) begin
            n_st = ST_UNSUP;
        end else if (r_dst_fmt > FMT_I32) begin
            if (r_f3.nan) begin
                n_res = fp_pack(r_dst_fmt, r_f3.sign, s4_emax, s4_pm);
            end else if (r_f3.inf) begin
                n_res = fp_pack(r_dst_fmt, r_f3.sign, s4_emax, 23'd0);
            end else if (r_f3.zero) begin
                n_res = fp_pack(r_dst_fmt, r_f3.sign, 8'd0, 23'd0);
            end else if (s4_norm) begin
                if (s4_eb >= $signed({3'd0, s4_emax})) begin
                    n_res = s4_inf_ok ? fp_pack(r_dst_fmt, r_f3.sign, s4_emax, 23'd0)
                                      : fp_pack(r_dst_fmt, r_f3.sign, s4_emax - 8'd1,
                                                s4_mmask);
                end else begin
                    n_res = fp_pack(r_dst_fmt, r_f3.sign, s4_eb[7:0],
                                    s4_n[22:0] & s4_mmask);
                end
            end else begin
                n_res = fp_pack(r_dst_fmt, r_f3.sign, 8'd0, s4_n[22:0]);
            end
        end else begin
            s4_bad = r_f3.nan || r_f3.inf
                     || (!r_f3.zero && (r_big3 || (r_f3.sign ? (r_n3 > s4_lim)
                                                             : (r_n3 >= s4_lim))));
            if (s4_bad) begin
                n_st = ST_INVALID;
            end else begin
                n_res = s4_v[31:0] & 32'((34'd1 << s4_w) - 34'd1);
            end
        end
    end

    logic [31:0] r_res;
    logic [1:0]  r_st;
    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_res <= n_res;
            r_st  <= n_st;
        end
    end
    assign o_result_word = r_res;
    assign o_status      = r_st;

endmodule

@@ rtl/nfc_checker.sv @@
// port-level checks of the format converter, bound to the top level
`include "numeric_format_converter_core_assert.svh"

module nfc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [31:0]                 o_result_word,
    input logic [1:0]                  o_status
);
    import nfc_pkg::*;

    logic [3:0] r_cnt, n_cnt;
    logic       in_acc, out_acc;

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt + 4'(in_acc) - 4'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // words in flight never exceed the pipe depth
    `NFC_ASSERT_NOW(a_depth, 1'b1, r_cnt <= 4'(MAX_INFLIGHT))
    // a result needs a word accepted earlier
    `NFC_ASSERT_NOW(a_no_phantom, o_valid, r_cnt != 4'd0)
    // error words carry a zero result
    `NFC_ASSERT_NOW(a_err_zero, o_valid && o_status != ST_OK, o_result_word == 32'd0)
    // stalled result holds
    `NFC_ASSERT_NEXT(a_hold, o_valid && !i_ready,
                     o_valid && $stable(o_result_word) && $stable(o_status))

endmodule

bind numeric_format_converter_core nfc_checker u_nfc_checker (.*);
